// ----- hdl/acd_pkg.sv -----
package acd_pkg;

  localparam int STAMP_BITS = 48;
  localparam int CAP_BITS = 7;
  localparam int CAP_RESET = 4 * 10;
  localparam int NUM_TRACK = 5;

  typedef enum logic [2:0] {
    LIST_FREE = 3'd0,
    LIST_T1   = 3'd1,
    LIST_T2   = 3'd2,
    LIST_B1   = 3'd3,
    LIST_B2   = 3'd4
  } list_t;

  typedef enum logic [2:0] {
    OUTCOME_MISS     = 3'd0,
    OUTCOME_T1_HIT   = 3'd1,
    OUTCOME_T2_HIT   = 3'd2,
    OUTCOME_B1_GHOST = 3'd3,
    OUTCOME_B2_GHOST = 3'd4
  } outcome_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DECIDE,
    ST_DEMOTE,
    ST_SCAN_ANY,
    ST_INSERT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic  hit_found;
    logic  free_found;
    list_t hit_list;
  } scan_flags_t;

endpackage

// ----- hdl/acd_ram.sv -----
module acd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/acd_div.sv -----
module acd_div #(
  parameter int W = 8,
  localparam int CNTW = $clog2(W + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  logic          busy;
  logic [CNTW-1:0] cnt;
  logic [W:0]    rem;
  logic [W-1:0]  dsr;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted = {rem[W-1:0], quotient[W-1]};
  assign fits = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNTW'(W);
        rem      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
      end else if (busy) begin
        rem      <= fits ? (shifted - {1'b0, dsr}) : shifted;
        quotient <= {quotient[W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/acd_scan.sv -----
module acd_scan #(
  parameter int SLOTS = 128,
  parameter int KEY_BITS = 32,
  localparam int SW = $clog2(SLOTS)
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic [KEY_BITS-1:0]                         key,
  output logic [SW-1:0]                               rd_addr,
  input  acd_pkg::list_t                              rd_list,
  input  logic [KEY_BITS-1:0]                         rd_key,
  input  logic [acd_pkg::STAMP_BITS-1:0]              rd_stamp,
  output logic                                        done,
  output acd_pkg::scan_flags_t                        flags,
  output logic [SW-1:0]                               hit_idx,
  output logic [SW-1:0]                               free_idx,
  output logic [acd_pkg::NUM_TRACK-1:0]               lru_found,
  output logic [acd_pkg::NUM_TRACK-1:0][SW-1:0]       lru_idx,
  output logic [acd_pkg::NUM_TRACK-1:0][KEY_BITS-1:0] lru_key,
  output acd_pkg::list_t                              any_list
);

  logic                                              busy;
  logic [SW:0]                                       cnt;
  logic                                              issue;
  logic                                              pv;
  logic [SW-1:0]                                     pidx;
  logic                                              last;
  logic [acd_pkg::NUM_TRACK-1:0]                     member;
  logic [acd_pkg::NUM_TRACK-1:0][acd_pkg::STAMP_BITS-1:0] lru_stamp;

  assign issue = busy && (cnt < (SW + 1)'(SLOTS));
  assign rd_addr = cnt[SW-1:0];
  assign last = pv && (pidx == SW'(SLOTS - 1));

  always_comb begin
    for (int j = 0; j < acd_pkg::NUM_TRACK; j++) begin
      if (j == 0) begin
        member[j] = rd_list != acd_pkg::LIST_FREE;
      end else begin
        member[j] = rd_list == acd_pkg::list_t'(3'(j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      cnt              <= '0;
      pv               <= 1'b0;
      done             <= 1'b0;
      flags.hit_found  <= 1'b0;
      flags.free_found <= 1'b0;
      lru_found        <= '0;
    end else begin
      done <= last;
      if (start) begin
        busy             <= 1'b1;
        cnt              <= '0;
        pv               <= 1'b0;
        flags.hit_found  <= 1'b0;
        flags.free_found <= 1'b0;
        lru_found        <= '0;
      end else begin
        pv   <= issue;
        pidx <= cnt[SW-1:0];
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
        if (last) begin
          busy <= 1'b0;
        end
        if (pv) begin
          if (!flags.hit_found && member[0] && rd_key == key) begin
            flags.hit_found <= 1'b1;
            flags.hit_list  <= rd_list;
            hit_idx         <= pidx;
          end
          if (!flags.free_found && !member[0]) begin
            flags.free_found <= 1'b1;
            free_idx         <= pidx;
          end
          for (int j = 0; j < acd_pkg::NUM_TRACK; j++) begin
            if (member[j] && (!lru_found[j] || rd_stamp < lru_stamp[j])) begin
              lru_found[j] <= 1'b1;
              lru_idx[j]   <= pidx;
              lru_key[j]   <= rd_key;
              lru_stamp[j] <= rd_stamp;
              if (j == 0) begin
                any_list <= rd_list;
              end
            end
          end
        end
      end
    end
  end

endmodule

// ----- hdl/arc_cache_directory_unit.sv -----
// Adaptive replacement cache directory. Each word on the request channel
// (in_valid, in_ready, request_key) is looked up in a directory of twice
// the cache capacity, and exactly one result word leaves on the result
// channel (out_valid, out_ready) with the outcome, the slot now holding the
// key, any dropped or demoted key, the adaptive T1 target and the counters.
// The capacity register is written through cfg_write_en and cfg_write_data;
// the user must do so only while the block is idle; the block does not enforce it.
// One request is handled at a time. Each request takes one pass over the
// directory memory that finds the key, the first free slot and the oldest
// entry of every list, before its result word is loaded. A ghost hit whose
// divisor is nonzero adds a run of the iterative divider. A miss that finds
// no free slot and drops no entry adds a second pass over the directory.
// After reset the directory memory is cleared one slot a cycle, and in_ready
// stays low meanwhile.
// A result waits in an output register. When the receiver stalls, the next
// request is still accepted and processed, and it waits only before its own
// result is loaded.
module arc_cache_directory_unit #(
  parameter int MAX_CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [6:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] request_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic [6:0]  slot_index,
  output logic        dropped_valid,
  output logic [31:0] dropped_key,
  output logic        demoted_valid,
  output logic [31:0] demoted_key,
  output logic [6:0]  target_now,
  output logic [31:0] hits_total,
  output logic [31:0] misses_total
);

  localparam int SLOTS = 2 * MAX_CAPACITY;
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int CW = $clog2(MAX_CAPACITY + 1);
  localparam int EW = LW + 2;
  localparam int SB = acd_pkg::STAMP_BITS;
  localparam int RW = 3 + KEY_BITS + SB;

  acd_pkg::state_t state, state_next;

  logic [acd_pkg::CAP_BITS-1:0] capacity;
  logic [SW-1:0]       clr_idx;
  logic [KEY_BITS-1:0] req_key;
  logic [SB-1:0]       stamp_counter;
  logic [LW-1:0]       len_recent, len_frequent, len_ghost_recent, len_ghost_frequent;
  logic [LW-1:0]       len_recent_next, len_frequent_next;
  logic [LW-1:0]       len_ghost_recent_next, len_ghost_frequent_next;
  logic [CW-1:0]       target_recent;
  logic [31:0]         hit_counter, miss_counter;

  acd_pkg::outcome_t   res_outcome;
  logic [SW-1:0]       res_slot;
  logic                res_drop_valid;
  logic [KEY_BITS-1:0] res_drop_key;
  logic                res_dem_valid;
  logic [KEY_BITS-1:0] res_dem_key;
  logic [SW-1:0]       dem_idx;
  acd_pkg::list_t      dem_list;
  logic                fb_pending;

  logic                ram_we;
  logic [SW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata;
  logic [SW-1:0]       ram_raddr;
  logic [RW-1:0]       ram_rdata;
  acd_pkg::list_t      rd_list;

  logic                scan_start;
  logic                scan_done;
  acd_pkg::scan_flags_t flags;
  logic [SW-1:0]       hit_idx, free_idx;
  logic [acd_pkg::NUM_TRACK-1:0]               lru_found;
  logic [acd_pkg::NUM_TRACK-1:0][SW-1:0]       lru_idx;
  logic [acd_pkg::NUM_TRACK-1:0][KEY_BITS-1:0] lru_key;
  acd_pkg::list_t      any_list;

  logic                div_start, div_done;
  logic [LW-1:0]       div_dividend, div_divisor, div_q;

  logic [7:0]          cap_round;
  logic [CW-1:0]       c_eff;
  logic [EW-1:0]       c_ext, l1, total, t_sum;
  logic                ghost, from_b2, div_nz, rep, drop_req, use_t1;
  logic                drop_en, demote_en, use_free, need_fb, out_free;
  logic [LW-1:0]       d_step;
  logic [CW-1:0]       p_new;
  acd_pkg::list_t      drop_list, src_list, dst_list, ins_list;
  logic [SW-1:0]       miss_slot, ins_idx;
  logic [LW-1:0]       ln [acd_pkg::NUM_TRACK];

  acd_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_dir (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_list = acd_pkg::list_t'(ram_rdata[RW-1 -: 3]);

  acd_scan #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .key       (req_key),
    .rd_addr   (ram_raddr),
    .rd_list   (rd_list),
    .rd_key    (ram_rdata[SB +: KEY_BITS]),
    .rd_stamp  (ram_rdata[SB-1:0]),
    .done      (scan_done),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx),
    .lru_found (lru_found),
    .lru_idx   (lru_idx),
    .lru_key   (lru_key),
    .any_list  (any_list)
  );

  acd_div #(.W(LW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    cap_round = ({1'b0, capacity} + 8'd3) & 8'hFC;
    if (cap_round < 8'd4) begin
      c_eff = CW'(4);
    end else if (32'(cap_round) > 32'(MAX_CAPACITY)) begin
      c_eff = CW'(MAX_CAPACITY);
    end else begin
      c_eff = CW'(cap_round);
    end
  end

  assign ghost = flags.hit_found &&
                 (flags.hit_list == acd_pkg::LIST_B1 || flags.hit_list == acd_pkg::LIST_B2);
  assign from_b2 = flags.hit_found && flags.hit_list == acd_pkg::LIST_B2;
  assign div_dividend = (flags.hit_list == acd_pkg::LIST_B1) ? len_ghost_frequent
                                                              : len_ghost_recent;
  assign div_divisor = (flags.hit_list == acd_pkg::LIST_B1) ? len_ghost_recent
                                                             : len_ghost_frequent;
  assign div_nz = div_divisor != '0;
  assign div_start = (state == acd_pkg::ST_SCAN) && scan_done && ghost && div_nz;
  assign scan_start = (state == acd_pkg::ST_IDLE && in_valid) ||
                      (state == acd_pkg::ST_DEMOTE && fb_pending);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    d_step = (!div_nz || div_q == '0) ? LW'(1) : div_q;
    t_sum = EW'(target_recent) + EW'(d_step);
    c_ext = EW'(c_eff);
    p_new = target_recent;
    if (ghost && !from_b2) begin
      p_new = (t_sum > c_ext) ? c_eff : CW'(t_sum);
    end else if (ghost) begin
      p_new = (EW'(target_recent) > EW'(d_step)) ?
              CW'(EW'(target_recent) - EW'(d_step)) : '0;
    end

    l1 = EW'(len_recent) + EW'(len_ghost_recent);
    total = l1 + EW'(len_frequent) + EW'(len_ghost_frequent);
    rep = 1'b0;
    drop_req = 1'b0;
    drop_list = acd_pkg::LIST_FREE;
    if (flags.hit_found) begin
      rep = ghost;
    end else if (l1 >= c_ext) begin
      drop_req = 1'b1;
      if (EW'(len_recent) < c_ext) begin
        drop_list = acd_pkg::LIST_B1;
        rep = 1'b1;
      end else begin
        drop_list = acd_pkg::LIST_T1;
      end
    end else if (total >= c_ext) begin
      rep = 1'b1;
      if (total >= (c_ext << 1)) begin
        drop_req = 1'b1;
        drop_list = acd_pkg::LIST_B2;
      end
    end

    use_t1 = (len_recent != '0) && ((EW'(len_recent) > EW'(p_new)) ||
             ((EW'(len_recent) == EW'(p_new)) && from_b2));
    src_list = use_t1 ? acd_pkg::LIST_T1 : acd_pkg::LIST_T2;
    dst_list = use_t1 ? acd_pkg::LIST_B1 : acd_pkg::LIST_B2;
    drop_en = drop_req && lru_found[drop_list];
    demote_en = rep && lru_found[src_list];

    use_free = flags.free_found && (!drop_en || free_idx < lru_idx[drop_list]);
    miss_slot = use_free ? free_idx : lru_idx[drop_list];
    need_fb = !flags.free_found && !drop_en;

    ins_list = flags.hit_found ? acd_pkg::LIST_T2 : acd_pkg::LIST_T1;
    if (flags.hit_found) begin
      ins_idx = hit_idx;
    end else if (fb_pending) begin
      ins_idx = lru_found[0] ? lru_idx[0] : '0;
    end else begin
      ins_idx = res_slot;
    end
  end

  always_comb begin
    ln[0] = '0;
    ln[1] = len_recent;
    ln[2] = len_frequent;
    ln[3] = len_ghost_recent;
    ln[4] = len_ghost_frequent;
    case (state)
      acd_pkg::ST_DECIDE: begin
        if (drop_en && ln[drop_list] != '0) begin
          ln[drop_list] = ln[drop_list] - 1'b1;
        end
        if (demote_en) begin
          if (ln[src_list] != '0) begin
            ln[src_list] = ln[src_list] - 1'b1;
          end
          ln[dst_list] = ln[dst_list] + 1'b1;
        end
      end
      acd_pkg::ST_INSERT: begin
        if (fb_pending && lru_found[0] && ln[any_list] != '0) begin
          ln[any_list] = ln[any_list] - 1'b1;
        end
        if (flags.hit_found && ln[flags.hit_list] != '0) begin
          ln[flags.hit_list] = ln[flags.hit_list] - 1'b1;
        end
        ln[ins_list] = ln[ins_list] + 1'b1;
      end
      default: begin
      end
    endcase
    len_recent_next = ln[1];
    len_frequent_next = ln[2];
    len_ghost_recent_next = ln[3];
    len_ghost_frequent_next = ln[4];
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = ins_idx;
    ram_wdata = {ins_list, req_key, stamp_counter};
    case (state)
      acd_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = {acd_pkg::LIST_FREE, {(RW - 3){1'b0}}};
      end
      acd_pkg::ST_DECIDE: begin
        ram_we = drop_en;
        ram_waddr = lru_idx[drop_list];
        ram_wdata = {acd_pkg::LIST_FREE, lru_key[drop_list], stamp_counter};
      end
      acd_pkg::ST_DEMOTE: begin
        ram_we = res_dem_valid;
        ram_waddr = dem_idx;
        ram_wdata = {dem_list, res_dem_key, stamp_counter};
      end
      acd_pkg::ST_INSERT: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      acd_pkg::ST_CLEAR: begin
        if (clr_idx == SW'(SLOTS - 1)) state_next = acd_pkg::ST_IDLE;
      end
      acd_pkg::ST_IDLE: begin
        if (in_valid) state_next = acd_pkg::ST_SCAN;
      end
      acd_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = (ghost && div_nz) ? acd_pkg::ST_DIV : acd_pkg::ST_DECIDE;
        end
      end
      acd_pkg::ST_DIV: begin
        if (div_done) state_next = acd_pkg::ST_DECIDE;
      end
      acd_pkg::ST_DECIDE: state_next = acd_pkg::ST_DEMOTE;
      acd_pkg::ST_DEMOTE: begin
        state_next = fb_pending ? acd_pkg::ST_SCAN_ANY : acd_pkg::ST_INSERT;
      end
      acd_pkg::ST_SCAN_ANY: begin
        if (scan_done) state_next = acd_pkg::ST_INSERT;
      end
      acd_pkg::ST_INSERT: state_next = acd_pkg::ST_RESULT;
      acd_pkg::ST_RESULT: begin
        if (out_free) state_next = acd_pkg::ST_IDLE;
      end
      default: state_next = acd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == acd_pkg::ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= acd_pkg::ST_CLEAR;
      clr_idx            <= '0;
      capacity           <= acd_pkg::CAP_BITS'(acd_pkg::CAP_RESET);
      stamp_counter      <= '0;
      len_recent         <= '0;
      len_frequent       <= '0;
      len_ghost_recent   <= '0;
      len_ghost_frequent <= '0;
      target_recent      <= '0;
      hit_counter        <= '0;
      miss_counter       <= '0;
      fb_pending         <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      state              <= state_next;
      len_recent         <= len_recent_next;
      len_frequent       <= len_frequent_next;
      len_ghost_recent   <= len_ghost_recent_next;
      len_ghost_frequent <= len_ghost_frequent_next;
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (state == acd_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == acd_pkg::ST_IDLE && in_valid) begin
        req_key <= KEY_BITS'(request_key);
      end
      if (state == acd_pkg::ST_DECIDE) begin
        target_recent  <= p_new;
        res_drop_valid <= drop_en;
        res_drop_key   <= drop_en ? lru_key[drop_list] : '0;
        res_dem_valid  <= demote_en;
        res_dem_key    <= demote_en ? lru_key[src_list] : '0;
        dem_idx        <= lru_idx[src_list];
        dem_list       <= dst_list;
        res_slot       <= flags.hit_found ? hit_idx : miss_slot;
        fb_pending     <= !flags.hit_found && need_fb;
        if (flags.hit_found) begin
          hit_counter <= hit_counter + 1'b1;
          case (flags.hit_list)
            acd_pkg::LIST_T1: res_outcome <= acd_pkg::OUTCOME_T1_HIT;
            acd_pkg::LIST_T2: res_outcome <= acd_pkg::OUTCOME_T2_HIT;
            acd_pkg::LIST_B1: res_outcome <= acd_pkg::OUTCOME_B1_GHOST;
            default:          res_outcome <= acd_pkg::OUTCOME_B2_GHOST;
          endcase
        end else begin
          miss_counter <= miss_counter + 1'b1;
          res_outcome  <= acd_pkg::OUTCOME_MISS;
        end
      end
      if (state == acd_pkg::ST_DEMOTE && res_dem_valid) begin
        stamp_counter <= stamp_counter + 1'b1;
      end
      if (state == acd_pkg::ST_INSERT) begin
        stamp_counter <= stamp_counter + 1'b1;
        res_slot      <= ins_idx;
        fb_pending    <= 1'b0;
        if (fb_pending) begin
          res_drop_valid <= lru_found[0];
          res_drop_key   <= lru_found[0] ? lru_key[0] : '0;
        end
      end
      if (state == acd_pkg::ST_RESULT && out_free) begin
        out_valid     <= 1'b1;
        outcome       <= res_outcome;
        slot_index    <= 7'(res_slot);
        dropped_valid <= res_drop_valid;
        dropped_key   <= 32'(res_drop_key);
        demoted_valid <= res_dem_valid;
        demoted_key   <= 32'(res_dem_key);
        target_now    <= 7'(target_recent);
        hits_total    <= hit_counter;
        misses_total  <= miss_counter;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    state == acd_pkg::ST_INSERT |=> stamp_counter == $past(stamp_counter) + 1'b1)
    else $error("stamp counter did not advance on insert");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    state == acd_pkg::ST_RESULT |->
      (EW'(len_recent) + EW'(len_frequent) + EW'(len_ghost_recent) +
       EW'(len_ghost_frequent)) <= EW'(SLOTS))
    else $error("list lengths exceed the directory size");

  a_hit_no_drop: assert property (@(posedge clk) disable iff (rst)
    state == acd_pkg::ST_RESULT && res_outcome != acd_pkg::OUTCOME_MISS |-> !res_drop_valid)
    else $error("a hit dropped a directory entry");

  a_scan_owner: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == acd_pkg::ST_SCAN || state == acd_pkg::ST_SCAN_ANY)
    else $error("directory pass finished outside a scan state");

endmodule

// ----- sim/tb_arc_cache_directory_unit.sv -----
module tb_arc_cache_directory_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT = 128;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    acd_pkg::outcome_t kind;
    logic [6:0]  slot;
    logic        drop_v;
    logic [31:0] drop_k;
    logic        demote_v;
    logic [31:0] demote_k;
    logic [6:0]  target;
    logic [31:0] hits;
    logic [31:0] misses;
  } arc_result_t;

  typedef struct {
    logic [31:0] key;
    bit          typed;
    arc_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [6:0]  cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] request_key = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  outcome;
  logic [6:0]  slot_index;
  logic        dropped_valid;
  logic [31:0] dropped_key;
  logic        demoted_valid;
  logic [31:0] demoted_key;
  logic [6:0]  target_now;
  logic [31:0] hits_total;
  logic [31:0] misses_total;

  arc_cache_directory_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready), .request_key(request_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .outcome(outcome), .slot_index(slot_index),
    .dropped_valid(dropped_valid), .dropped_key(dropped_key),
    .demoted_valid(demoted_valid), .demoted_key(demoted_key),
    .target_now(target_now), .hits_total(hits_total), .misses_total(misses_total)
  );

  always #5 clk = ~clk;

  // Directory mirror.
  logic [31:0]    dir_key[SLOT_COUNT];
  acd_pkg::list_t dir_list[SLOT_COUNT];
  logic [47:0]    dir_stamp[SLOT_COUNT];
  logic [47:0] stamp_now;
  int unsigned n_t1, n_t2, n_b1, n_b2, p_target;
  logic [31:0] hit_count, miss_count;
  logic [6:0]  cap_reg;
  bit          drop_flag, demote_flag;
  logic [31:0] drop_word, demote_word;

  arc_result_t expected_words[$];
  int          error_count = 0;
  int          kind_count[5];
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;

  function automatic int unsigned effective_capacity();
    int unsigned v;
    v = (int'(cap_reg) + 3) & ~3;
    if (v < 4) v = 4;
    if (v > 64) v = 64;
    return v;
  endfunction

  function automatic int oldest_in(acd_pkg::list_t l, bit any_list);
    int best;
    bit member;
    best = -1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      member = any_list ? (dir_list[i] != acd_pkg::LIST_FREE) : (dir_list[i] == l);
      if (member && (best < 0 || dir_stamp[i] < dir_stamp[best])) best = i;
    end
    return best;
  endfunction

  task automatic adjust_len(acd_pkg::list_t l, bit grow);
    case (l)
      acd_pkg::LIST_T1: begin
        if (grow) n_t1++; else if (n_t1 != 0) n_t1--;
      end
      acd_pkg::LIST_T2: begin
        if (grow) n_t2++; else if (n_t2 != 0) n_t2--;
      end
      acd_pkg::LIST_B1: begin
        if (grow) n_b1++; else if (n_b1 != 0) n_b1--;
      end
      acd_pkg::LIST_B2: begin
        if (grow) n_b2++; else if (n_b2 != 0) n_b2--;
      end
      default: begin
      end
    endcase
  endtask

  task automatic relist(int s, acd_pkg::list_t l);
    if (dir_list[s] != acd_pkg::LIST_FREE) adjust_len(dir_list[s], 1'b0);
    dir_list[s] = l;
    adjust_len(l, 1'b1);
    dir_stamp[s] = stamp_now;
    stamp_now = stamp_now + 48'd1;
  endtask

  task automatic evict_oldest(acd_pkg::list_t l, bit any_list);
    int s;
    s = oldest_in(l, any_list);
    if (s >= 0) begin
      adjust_len(dir_list[s], 1'b0);
      dir_list[s] = acd_pkg::LIST_FREE;
      drop_flag = 1'b1;
      drop_word = dir_key[s];
    end
  endtask

  task automatic demote_one(bit from_b2);
    int s;
    if (n_t1 >= 1 && (n_t1 > p_target || (n_t1 == p_target && from_b2))) begin
      s = oldest_in(acd_pkg::LIST_T1, 1'b0);
      if (s >= 0) relist(s, acd_pkg::LIST_B1);
    end else begin
      s = oldest_in(acd_pkg::LIST_T2, 1'b0);
      if (s >= 0) relist(s, acd_pkg::LIST_B2);
    end
    if (s >= 0) begin
      demote_flag = 1'b1;
      demote_word = dir_key[s];
    end
  endtask

  task automatic lookup_and_update(input logic [31:0] key, output arc_result_t r);
    int unsigned c, d, l1, total;
    int s;
    c = effective_capacity();
    s = -1;
    drop_flag = 1'b0;
    demote_flag = 1'b0;
    drop_word = '0;
    demote_word = '0;
    r.kind = acd_pkg::OUTCOME_MISS;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (s < 0 && dir_list[i] != acd_pkg::LIST_FREE && dir_key[i] == key) s = i;
    end
    if (s >= 0) begin
      hit_count++;
      case (dir_list[s])
        acd_pkg::LIST_T1: r.kind = acd_pkg::OUTCOME_T1_HIT;
        acd_pkg::LIST_T2: r.kind = acd_pkg::OUTCOME_T2_HIT;
        acd_pkg::LIST_B1: begin
          d = (n_b1 != 0) ? n_b2 / n_b1 : 1;
          if (d < 1) d = 1;
          p_target = (p_target + d > c) ? c : p_target + d;
          demote_one(1'b0);
          r.kind = acd_pkg::OUTCOME_B1_GHOST;
        end
        default: begin
          d = (n_b2 != 0) ? n_b1 / n_b2 : 1;
          if (d < 1) d = 1;
          p_target = (p_target > d) ? p_target - d : 0;
          demote_one(1'b1);
          r.kind = acd_pkg::OUTCOME_B2_GHOST;
        end
      endcase
      relist(s, acd_pkg::LIST_T2);
    end else begin
      l1 = n_t1 + n_b1;
      total = l1 + n_t2 + n_b2;
      miss_count++;
      if (l1 >= c) begin
        if (n_t1 < c) begin
          evict_oldest(acd_pkg::LIST_B1, 1'b0);
          demote_one(1'b0);
        end else begin
          evict_oldest(acd_pkg::LIST_T1, 1'b0);
        end
      end else if (total >= c) begin
        if (total >= 2 * c) evict_oldest(acd_pkg::LIST_B2, 1'b0);
        demote_one(1'b0);
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (s < 0 && dir_list[i] == acd_pkg::LIST_FREE) s = i;
      end
      if (s < 0) begin
        s = oldest_in(acd_pkg::LIST_FREE, 1'b1);
        evict_oldest(acd_pkg::LIST_FREE, 1'b1);
      end
      if (s < 0) s = 0;
      dir_key[s] = key;
      relist(s, acd_pkg::LIST_T1);
    end
    r.slot = s[6:0];
    r.drop_v = drop_flag;
    r.drop_k = drop_word;
    r.demote_v = demote_flag;
    r.demote_k = demote_word;
    r.target = p_target[6:0];
    r.hits = hit_count;
    r.misses = miss_count;
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", field, got, want,
             cycle_count);
    error_count++;
  endtask

  // Result channel: check accepted words and vary out_ready.
  always @(posedge clk) begin
    arc_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", {29'd0, outcome}, '0);
      end else begin
        w = expected_words.pop_front();
        if (outcome != w.kind) begin
          report_mismatch("outcome", {29'd0, outcome}, {29'd0, w.kind});
        end
        if (slot_index != w.slot) begin
          report_mismatch("slot_index", {25'd0, slot_index}, {25'd0, w.slot});
        end
        if (dropped_valid != w.drop_v) begin
          report_mismatch("dropped_valid", {31'd0, dropped_valid}, {31'd0, w.drop_v});
        end
        if (dropped_key != w.drop_k) report_mismatch("dropped_key", dropped_key, w.drop_k);
        if (demoted_valid != w.demote_v) begin
          report_mismatch("demoted_valid", {31'd0, demoted_valid}, {31'd0, w.demote_v});
        end
        if (demoted_key != w.demote_k) begin
          report_mismatch("demoted_key", demoted_key, w.demote_k);
        end
        if (target_now != w.target) begin
          report_mismatch("target_now", {25'd0, target_now}, {25'd0, w.target});
        end
        if (hits_total != w.hits) report_mismatch("hits_total", hits_total, w.hits);
        if (misses_total != w.misses) report_mismatch("misses_total", misses_total, w.misses);
        if (outcome < 5) kind_count[outcome]++;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_capacity(logic [6:0] value);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cap_reg = value;
    @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] key, bit typed, arc_result_t want);
    arc_result_t got;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    request_key <= key;
    do @(posedge clk); while (!in_ready);
    lookup_and_update(key, got);
    expected_words.push_back(typed ? want : got);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  stim_row_t directed[$];

  task automatic add_row(logic [31:0] key, bit typed, acd_pkg::outcome_t k, int slot,
                         int hits, int misses);
    stim_row_t r;
    r.key = key;
    r.typed = typed;
    r.want = '{k, slot[6:0], 1'b0, 32'd0, 1'b0, 32'd0, 7'd0, hits, misses};
    directed.push_back(r);
  endtask

  initial begin
    logic [6:0] phase_caps[6];
    logic [31:0] base, key;
    int unsigned pool;
    arc_result_t none;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      dir_list[i] = acd_pkg::LIST_FREE;
      dir_key[i] = '0;
      dir_stamp[i] = '0;
    end
    stamp_now = '0;
    n_t1 = 0; n_t2 = 0; n_b1 = 0; n_b2 = 0; p_target = 0;
    hit_count = '0; miss_count = '0;
    cap_reg = 7'(acd_pkg::CAP_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // From reset, then with the smallest capacity so that ghosts appear quickly.
    add_row(32'h0000_0000, 1, acd_pkg::OUTCOME_MISS, 0, 0, 1);
    add_row(32'hFFFF_FFFF, 1, acd_pkg::OUTCOME_MISS, 1, 0, 2);
    add_row(32'h0000_0000, 1, acd_pkg::OUTCOME_T1_HIT, 0, 1, 2);
    add_row(32'h0000_0000, 1, acd_pkg::OUTCOME_T2_HIT, 0, 2, 2);
    add_row(32'hFFFF_FFFF, 1, acd_pkg::OUTCOME_T1_HIT, 1, 3, 2);
    foreach (directed[i]) send_word(directed[i].key, directed[i].typed, directed[i].want);
    drain();
    write_capacity(7'd0);
    directed.delete();
    for (int i = 1; i <= 6; i++) add_row(i, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    add_row(1, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    add_row(2, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    add_row(32'h0000_0000, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    for (int i = 7; i <= 10; i++) add_row(i, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    add_row(32'hFFFF_FFFF, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    add_row(3, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    add_row(7, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    add_row(4, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    add_row(32'h8000_0000, 0, acd_pkg::OUTCOME_MISS, 0, 0, 0);
    foreach (directed[i]) send_word(directed[i].key, directed[i].typed, directed[i].want);
    drain();

    phase_caps = '{7'd127, 7'd4, 7'd64, 7'd40, 7'd0, 7'd3};
    phase_caps[4] = 7'($urandom_range(5, 63));
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        sender_idle_pct = 27; receiver_idle_pct = 72;
      end else if (ph < 4) begin
        sender_idle_pct = 72; receiver_idle_pct = 27;
      end else begin
        sender_idle_pct = 0; receiver_idle_pct = 0;
      end
      write_capacity(phase_caps[ph]);
      base = $urandom();
      pool = 3 * effective_capacity() + 2;
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 99) < 8) key = $urandom();
        else key = base + $urandom_range(0, pool);
        send_word(key, 0, none);
        if (ph == 2 && n == 120) begin
          in_valid <= 1'b0;
          while (expected_words.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Ran the directed rows and 1500 random requests over six capacity settings.");
    $display("Results seen: %0d miss, %0d T1, %0d T2, %0d B1 ghost, %0d B2 ghost.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/acd_pkg.sv
hdl/acd_ram.sv
hdl/acd_div.sv
hdl/acd_scan.sv
hdl/arc_cache_directory_unit.sv
sim/tb_arc_cache_directory_unit.sv
